/* design/gb5_pkg.sv */
// Shared types and constants for the 5x5 Gaussian blur stream.
package gb5_pkg;

  // Kernel geometry and pixel format
  localparam int KS          = 5;
  localparam int PIX_W       = 8;
  localparam int ROW_WORD_W  = (KS - 1) * PIX_W;  // four earlier rows per column
  localparam int WEIGHT_W    = 6;
  localparam int PSUM_W      = 15;                 // one weighted column, at most 27285
  localparam int SUM_W       = 17;                 // full window, at most 69615

  // Frame limits and configuration format
  localparam int DIM_W       = 11;
  localparam int ROW_W       = 10;
  localparam int MIN_DIM     = 5;
  localparam int MAX_HEIGHT  = 1024;
  localparam int CFG_IDX_W   = 1;
  localparam int DIM_RESET   = 512;

  // floor(s / 273) == (s * RECIP) >> RECIP_SHIFT for every s below 123817
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP = 17'd122911;
  localparam int RECIP_SHIFT = 25;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [PIX_W-1:0] pix_t;
  // element 0 is the oldest row of the column, element KS-1 the newest pixel
  typedef logic [0:KS-1][PIX_W-1:0] column_t;

  localparam weight_t KERNEL_W [KS][KS] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // Per-cycle controls broadcast to every window cell
  typedef struct packed {
    logic shift;     // take the neighbor's column
    logic load_sum;  // register the weighted column sum
  } cell_ctrl_t;

endpackage

/* design/gb5_if.sv */
// Valid/ready stream interfaces for pixel input and blurred output.
interface gb5_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [gb5_pkg::PIX_W-1:0] pixel_in;

  modport source(output valid, output cmd, output pixel_in, input ready);
  modport sink(input valid, input cmd, input pixel_in, output ready);
endinterface

interface gb5_out_if;
  logic valid;
  logic ready;
  logic [gb5_pkg::PIX_W-1:0] pixel_out;
  logic last_in_frame;

  modport source(output valid, output pixel_out, output last_in_frame, input ready);
  modport sink(input valid, input pixel_out, input last_in_frame, output ready);
endinterface

/* design/gaussian_blur_5x5_stream.sv */
// Top level of the streaming 5x5 Gaussian blur (kernel sum 273).
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    cmd, pixel_in
//   out_o    out  valid/ready    pixel_out, last_in_frame
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// One item per clock while out_o is not stalled; a result passes through the
// registered line memory read, window shift, column sums, window sum, divide.
// Items that give no result leave the pipe after the window shift.
// Output stalls back up stage by stage; empty stages fill without waiting.
// Reset clears counters, window and valids and sets both sizes to 512; the
// line memory is not cleared, stale entries only reach border results (zero).
module gaussian_blur_5x5_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gb5_in_if.sink                            in_i,
  gb5_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gb5_pkg::DIM_W-1:0]         cfg_data_i
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WID_W > gb5_pkg::DIM_W) ? WID_W : gb5_pkg::DIM_W;
  localparam int OC_W  = $clog2(MAX_WIDTH * gb5_pkg::MAX_HEIGHT);
  localparam int TOT_W = $clog2(MAX_WIDTH * gb5_pkg::MAX_HEIGHT + 1);

  // Configuration registers
  logic [gb5_pkg::DIM_W-1:0] line_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= gb5_pkg::DIM_W'(gb5_pkg::DIM_RESET);
      frame_height_q <= gb5_pkg::DIM_W'(gb5_pkg::DIM_RESET);
    end else if (cfg_we_i) begin
      unique case (gb5_pkg::cfg_idx_e'(cfg_idx_i))
        gb5_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        gb5_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped frame size and pixel count
  logic [CMP_W-1:0]          lw_ext;
  logic [WID_W-1:0]          width;
  logic [gb5_pkg::DIM_W-1:0] height;
  logic [TOT_W-1:0]          total;

  always_comb begin
    lw_ext = CMP_W'(line_width_q);
    if (lw_ext < CMP_W'(gb5_pkg::MIN_DIM)) begin
      width = WID_W'(gb5_pkg::MIN_DIM);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      width = WID_W'(MAX_WIDTH);
    end else begin
      width = WID_W'(lw_ext);
    end
    if (frame_height_q < gb5_pkg::DIM_W'(gb5_pkg::MIN_DIM)) begin
      height = gb5_pkg::DIM_W'(gb5_pkg::MIN_DIM);
    end else if (frame_height_q > gb5_pkg::DIM_W'(gb5_pkg::MAX_HEIGHT)) begin
      height = gb5_pkg::DIM_W'(gb5_pkg::MAX_HEIGHT);
    end else begin
      height = frame_height_q;
    end
    total = TOT_W'(width) * TOT_W'(height);
  end

  // Pipeline valids and load enables (a stage loads when empty or draining)
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic ld1, ld2, ld3, ld4, ldo;
  logic in_acc;

  assign ldo = !vo_q || out_o.ready;
  assign ld4 = !v4_q || ldo;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign in_i.ready = ld1;
  assign in_acc     = in_i.valid && ld1;

  // Raster position and result counting, resolved when a transaction is taken
  logic [COL_W-1:0]          in_col_q, in_col_d;
  logic [gb5_pkg::ROW_W-1:0] in_row_q, in_row_d;
  logic [OC_W-1:0]           out_cnt_q, out_cnt_d, oc_base;
  logic [TOT_W-1:0]          oc_inc;
  logic                      is_flush, pending, produce, blur_pos, emit, last;
  logic                      col_end, row_end;

  always_comb begin
    is_flush = gb5_pkg::cmd_e'(in_i.cmd) == gb5_pkg::CMD_FLUSH;
    pending  = (in_col_q == '0) && (in_row_q == '0) && (out_cnt_q != '0);
    produce  = (in_row_q > gb5_pkg::ROW_W'(2))
            || ((in_row_q == gb5_pkg::ROW_W'(2)) && (in_col_q >= COL_W'(2)));
    blur_pos = (in_row_q >= gb5_pkg::ROW_W'(4)) && (in_col_q >= COL_W'(4));
    emit     = is_flush ? pending : produce;
    // a pixel arriving during a pending tail drops that tail
    oc_base  = (!is_flush && pending) ? '0 : out_cnt_q;
    oc_inc   = TOT_W'(oc_base) + TOT_W'(1);
    last     = oc_inc >= total;
    col_end  = (WID_W'(in_col_q) + WID_W'(1)) >= width;
    row_end  = (gb5_pkg::DIM_W'(in_row_q) + gb5_pkg::DIM_W'(1)) >= height;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_cnt_d = out_cnt_q;
    if (in_acc) begin
      if (emit) begin
        out_cnt_d = last ? '0 : OC_W'(oc_inc);
      end else begin
        out_cnt_d = oc_base;
      end
      if (!is_flush) begin
        if (col_end) begin
          in_col_d = '0;
          in_row_d = row_end ? '0 : in_row_q + gb5_pkg::ROW_W'(1);
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
      end
    end
  end

  // Line memory
  logic [gb5_pkg::ROW_WORD_W-1:0] rd_data, wr_data;
  logic [COL_W-1:0]               s1_addr_q;
  gb5_pkg::pix_t                  s1_pix_q;
  logic                           s1_is_pix_q, s1_prod_q, s1_blur_q, s1_last_q;
  logic                           win_shift;

  assign win_shift = ld2 && v1_q && s1_is_pix_q;
  assign wr_data   = {rd_data[gb5_pkg::ROW_WORD_W-gb5_pkg::PIX_W-1:0], s1_pix_q};

  gb5_line_buf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rd_en_i  (in_acc),
    .rd_addr_i(in_col_q),
    .rd_data_o(rd_data),
    .wr_en_i  (win_shift),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(wr_data)
  );

  // Window: a chain of column cells, the new column enters at the right end
  gb5_pkg::cell_ctrl_t         cell_ctrl;
  gb5_pkg::column_t            chain [1:gb5_pkg::KS];
  logic [gb5_pkg::PSUM_W-1:0]  psum [gb5_pkg::KS];

  assign cell_ctrl.shift    = win_shift;
  assign cell_ctrl.load_sum = ld3 && v2_q;
  assign chain[gb5_pkg::KS] = {rd_data, s1_pix_q};

  for (genvar j = 0; j < gb5_pkg::KS; j++) begin : g_cell
    if (j > 0) begin : g_mid
      gb5_cell #(
        .COL(j)
      ) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctrl_i(cell_ctrl),
        .col_i (chain[j+1]),
        .col_o (chain[j]),
        .psum_o(psum[j])
      );
    end else begin : g_left
      gb5_cell #(
        .COL(j)
      ) u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctrl_i(cell_ctrl),
        .col_i (chain[j+1]),
        .col_o (),
        .psum_o(psum[j])
      );
    end
  end

  // Window sum and divide by 273
  logic [gb5_pkg::SUM_W-1:0]  sum_d, s4_sum_q;
  logic [gb5_pkg::PROD_W-1:0] quot_prod;
  gb5_pkg::pix_t              quot;

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < gb5_pkg::KS; j++) begin
      sum_d = sum_d + gb5_pkg::SUM_W'(psum[j]);
    end
  end

  assign quot_prod = gb5_pkg::PROD_W'(s4_sum_q) * gb5_pkg::PROD_W'(gb5_pkg::RECIP);
  assign quot      = quot_prod[gb5_pkg::RECIP_SHIFT +: gb5_pkg::PIX_W];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_cnt_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      vo_q      <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_cnt_q <= out_cnt_d;
      if (ld1) v1_q <= in_acc && (!is_flush || pending);
      if (ld2) v2_q <= v1_q && s1_prod_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ldo) vo_q <= v4_q;
    end
  end

  // Stage payloads
  logic          s2_blur_q, s2_last_q, s3_blur_q, s3_last_q, s4_blur_q, s4_last_q;
  gb5_pkg::pix_t o_pix_q;
  logic          o_last_q;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_addr_q   <= in_col_q;
      s1_pix_q    <= in_i.pixel_in;
      s1_is_pix_q <= !is_flush;
      s1_prod_q   <= emit;
      s1_blur_q   <= !is_flush && blur_pos;
      s1_last_q   <= last;
    end
    if (ld2) begin
      s2_blur_q <= s1_blur_q;
      s2_last_q <= s1_last_q;
    end
    if (ld3) begin
      s3_blur_q <= s2_blur_q;
      s3_last_q <= s2_last_q;
    end
    if (ld4) begin
      s4_blur_q <= s3_blur_q;
      s4_last_q <= s3_last_q;
      s4_sum_q  <= sum_d;
    end
    if (ldo) begin
      o_pix_q  <= s4_blur_q ? quot : '0;
      o_last_q <= s4_last_q;
    end
  end

  assign out_o.valid         = vo_q;
  assign out_o.pixel_out     = o_pix_q;
  assign out_o.last_in_frame = o_last_q;

endmodule

/* design/gb5_line_buf.sv */
// Line memory: four earlier rows per column, one read and one write port.
module gb5_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr_i,
  output logic [gb5_pkg::ROW_WORD_W-1:0] rd_data_o,
  input  logic                           wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr_i,
  input  logic [gb5_pkg::ROW_WORD_W-1:0] wr_data_i
);

  logic [gb5_pkg::ROW_WORD_W-1:0] row_mem [DEPTH];
  logic [gb5_pkg::ROW_WORD_W-1:0] rd_data_q;

  // Registered read, plain write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= row_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/gb5_cell.sv */
// One window column: holds five pixels, passes them left, sums them weighted.
module gb5_cell #(
  parameter int COL = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gb5_pkg::cell_ctrl_t         ctrl_i,
  input  gb5_pkg::column_t            col_i,
  output gb5_pkg::column_t            col_o,
  output logic [gb5_pkg::PSUM_W-1:0]  psum_o
);

  gb5_pkg::column_t            col_q;
  logic [gb5_pkg::PSUM_W-1:0]  psum_d, psum_q;

  // Column shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  // Weighted column sum with this column's kernel weights
  always_comb begin
    psum_d = '0;
    for (int i = 0; i < gb5_pkg::KS; i++) begin
      psum_d = psum_d + gb5_pkg::PSUM_W'(gb5_pkg::KERNEL_W[i][COL])
                      * gb5_pkg::PSUM_W'(col_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      psum_q <= psum_d;
    end
  end

  assign col_o  = col_q;
  assign psum_o = psum_q;

endmodule
